@@ design/ohs_pkg.sv @@
// Package with shared constants and types of the hash set.
`default_nettype none
package ohs_pkg;
	localparam int MaxSlots = 1024;
	localparam int AddrW = $clog2(MaxSlots);
	localparam int SizeW = 11;
	localparam int KeyW = 32;
	localparam int CntW = 11;

	localparam logic [1:0] REQ_INSERT   = 2'd0;
	localparam logic [1:0] REQ_CONTAINS = 2'd1;
	localparam logic [1:0] REQ_REMOVE   = 2'd2;

	localparam logic [1:0] ST_EMPTY    = 2'd0;
	localparam logic [1:0] ST_DELETED  = 2'd1;
	localparam logic [1:0] ST_OCCUPIED = 2'd2;

	localparam logic [1:0] CFG_TABLE_SIZE = 2'd0;
	localparam logic [1:0] CFG_SECOND_MOD = 2'd1;
	localparam logic [1:0] CFG_PROBE_MODE = 2'd2;

	typedef struct packed {
		logic [1:0]      req_type;
		logic [KeyW-1:0] key;
	} req_t;

	typedef struct packed {
		logic            success;
		logic [CntW-1:0] load_count;
	} rsp_t;

	// Decoded item handed from the front end to the probe engine.
	typedef struct packed {
		logic [1:0]       req_type;
		logic [KeyW-1:0]  key;
		logic [SizeW-1:0] size;
		logic [SizeW-1:0] rmod;
		logic             mode;
	} job_t;
endpackage
`default_nettype wire

@@ design/ohs_if.sv @@
// Valid/ready channel interface carrying one request or result beat.
`default_nettype none
interface ohs_req_if;
	import ohs_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] req_type;
	logic [KeyW-1:0] key;
	modport source (output valid, req_type, key, input ready);
	modport sink (input valid, req_type, key, output ready);
endinterface

interface ohs_rsp_if;
	import ohs_pkg::*;
	logic valid;
	logic ready;
	logic success;
	logic [CntW-1:0] load_count;
	modport source (output valid, success, load_count, input ready);
	modport sink (input valid, success, load_count, output ready);
endinterface
`default_nettype wire

@@ design/ohs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module ohs_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(Depth)-1:0] waddr,
	input  wire [Width-1:0]         wdata,
	input  wire [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]        rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ design/ohs_front.sv @@
// Front end: takes request beats, clamps configuration, queues decoded jobs.
`default_nettype none
module ohs_front import ohs_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	ohs_req_if.sink          req,
	input  wire [SizeW-1:0]  table_size_q,
	input  wire [SizeW-1:0]  second_mod_q,
	input  wire              probe_mode_q,
	output logic             job_valid,
	input  wire              job_ready,
	output job_t             job
);
	// Two-entry queue.
	job_t       fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic [SizeW-1:0] size_c, rmod_c;
	job_t in_job;
	logic push, pop;

	always_comb begin
		size_c = table_size_q;
		if (size_c == '0) size_c = SizeW'(1);
		if (size_c > SizeW'(MaxSlots)) size_c = SizeW'(MaxSlots);
		rmod_c = (second_mod_q == '0) ? SizeW'(1) : second_mod_q;
		in_job.req_type = req.req_type;
		in_job.key = req.key;
		in_job.size = size_c;
		in_job.rmod = rmod_c;
		in_job.mode = probe_mode_q;
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push = req.valid && req.ready;
	assign job_valid = (cnt_q != 2'd0);
	assign pop = job_valid && job_ready;
	assign job = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= in_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

@@ design/ohs_back.sv @@
// Back end: probe sequencer over the key and status memories.
`default_nettype none
module ohs_back import ohs_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         job_valid,
	output logic        job_ready,
	input  job_t        job,
	ohs_rsp_if.source   rsp,
	output logic        clearing
);
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_MOD   = 3'd2;
	localparam logic [2:0] S_ADDR  = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_EVAL  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]       state_q;
	job_t             job_q;
	logic [KeyW-1:0]  step_q;      // per-probe increment for double hashing
	logic [KeyW-1:0]  off_q;       // accumulated offset i*i or i*step
	logic [KeyW-1:0]  sq_inc_q;    // 2i+1 for quadratic
	logic [KeyW-1:0]  rem_q;       // iterative remainder working value
	logic [5:0]       bit_q;
	logic             mod_for_r_q; // remainder pass computes key mod R
	logic [SizeW-1:0] probes_q;
	logic [AddrW-1:0] pos_q;
	logic [AddrW:0]   clr_q;
	logic [CntW-1:0]  count_q;
	logic             ok_q;
	logic             out_valid_q;
	logic             out_ok_q;

	logic [1:0]       st_rdata;
	logic [KeyW-1:0]  key_rdata;
	logic             st_we, key_we;
	logic [AddrW-1:0] st_waddr;
	logic [1:0]       st_wdata;
	logic [SizeW-1:0] divisor;
	logic [KeyW+SizeW:0] trial;
	logic [KeyW-1:0]  sum;

	assign clearing = (state_q == S_CLEAR);
	assign job_ready = (state_q == S_IDLE) && !out_valid_q;
	assign rsp.valid = out_valid_q;
	assign rsp.success = out_ok_q;
	assign rsp.load_count = count_q;

	assign divisor = mod_for_r_q ? job_q.rmod : job_q.size;
	assign sum = job_q.key + off_q;

	// Restoring division, one quotient bit per cycle; remainder only.
	// The trial is wide enough that the shifted divisor never wraps.
	always_comb begin
		trial = {{(SizeW+1){1'b0}}, rem_q} - ({{(KeyW+1){1'b0}}, divisor} << bit_q);
	end

	ohs_ram #(.Width(2), .Depth(MaxSlots)) u_status (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(pos_q), .rdata(st_rdata)
	);
	ohs_ram #(.Width(KeyW), .Depth(MaxSlots)) u_keys (
		.clk(clk), .we(key_we), .waddr(pos_q), .wdata(job_q.key),
		.raddr(pos_q), .rdata(key_rdata)
	);

	always_comb begin
		st_we = 1'b0;
		key_we = 1'b0;
		st_waddr = pos_q;
		st_wdata = ST_EMPTY;
		if (state_q == S_CLEAR) begin
			st_we = 1'b1;
			st_waddr = clr_q[AddrW-1:0];
		end else if (state_q == S_EVAL) begin
			if (job_q.req_type == REQ_INSERT && st_rdata != ST_OCCUPIED) begin
				st_we = 1'b1;
				key_we = 1'b1;
				st_wdata = ST_OCCUPIED;
			end else if (job_q.req_type == REQ_REMOVE && st_rdata == ST_OCCUPIED
					&& key_rdata == job_q.key) begin
				st_we = 1'b1;
				st_wdata = ST_DELETED;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) job_q <= job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
			out_ok_q <= 1'b0;
			ok_q <= 1'b0;
			step_q <= '0;
			off_q <= '0;
			sq_inc_q <= '0;
			rem_q <= '0;
			bit_q <= '0;
			mod_for_r_q <= 1'b0;
			probes_q <= '0;
			pos_q <= '0;
		end else begin
			if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AddrW+1)'(MaxSlots - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (job_valid && job_ready) begin
						off_q <= '0;
						sq_inc_q <= KeyW'(1);
						probes_q <= '0;
						ok_q <= 1'b0;
						if (job.req_type != REQ_INSERT && job.req_type != REQ_CONTAINS
								&& job.req_type != REQ_REMOVE) begin
							out_ok_q <= 1'b0;
							out_valid_q <= 1'b1;
						end else begin
							rem_q <= job.key;
							bit_q <= 6'(KeyW - 1);
							mod_for_r_q <= job.mode;
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					if (!trial[KeyW+SizeW]) rem_q <= trial[KeyW-1:0];
					bit_q <= bit_q - 6'd1;
					if (bit_q == 6'd0) state_q <= S_ADDR;
				end
				S_ADDR: begin
					if (mod_for_r_q) begin
						// rem_q holds key mod R; derive the step and start the first probe.
						step_q <= KeyW'(job_q.rmod) - rem_q;
						mod_for_r_q <= 1'b0;
						rem_q <= sum;
						bit_q <= 6'(KeyW - 1);
						state_q <= S_MOD;
					end else begin
						pos_q <= rem_q[AddrW-1:0];
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_EVAL;
				S_EVAL: begin
					if (job_q.req_type == REQ_INSERT) begin
						if (st_rdata != ST_OCCUPIED) begin
							count_q <= count_q + CntW'(1);
							ok_q <= 1'b1;
							state_q <= S_DONE;
						end
					end else begin
						if (st_rdata == ST_EMPTY) begin
							state_q <= S_DONE;
						end else if (st_rdata == ST_OCCUPIED && key_rdata == job_q.key) begin
							ok_q <= 1'b1;
							if (job_q.req_type == REQ_REMOVE) count_q <= count_q - CntW'(1);
							state_q <= S_DONE;
						end
					end
					if (state_q == S_EVAL) begin
						probes_q <= probes_q + SizeW'(1);
						if (job_q.mode) begin
							off_q <= off_q + step_q;
						end else begin
							off_q <= off_q + sq_inc_q;
							sq_inc_q <= sq_inc_q + KeyW'(2);
						end
					end
				end
				S_DONE: begin
					out_ok_q <= ok_q;
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// Probe continuation is decided after the evaluation above.
			if (state_q == S_EVAL && !(
					(job_q.req_type == REQ_INSERT && st_rdata != ST_OCCUPIED) ||
					(job_q.req_type != REQ_INSERT && st_rdata == ST_EMPTY) ||
					(job_q.req_type != REQ_INSERT && st_rdata == ST_OCCUPIED
						&& key_rdata == job_q.key))) begin
				if (probes_q + SizeW'(1) == job_q.size) begin
					state_q <= S_DONE;
				end else begin
					rem_q <= job_q.key + (job_q.mode ? off_q + step_q : off_q + sq_inc_q);
					bit_q <= 6'(KeyW - 1);
					state_q <= S_MOD;
				end
			end
		end
	end
endmodule
`default_nettype wire

@@ design/open_addressing_hash_set.sv @@
// Top level of the open-addressing hash set of 32-bit keys.
// One result beat per request beat, in order. Each probe forms its slot
// position with the bit-serial remainder unit; in double-hash mode a first
// remainder pass computes key mod R for the step. Probes run up to the
// table size. After reset the status memory is cleared, during which the
// probe engine takes no job; the front-end queue still accepts up to two requests.
`default_nettype none
module open_addressing_hash_set import ohs_pkg::*; (
	input  wire             clk,
	input  wire             arst_n,
	ohs_req_if.sink         req,
	ohs_rsp_if.source       rsp,
	input  wire             cfg_we,
	input  wire [1:0]       cfg_index,
	input  wire [SizeW-1:0] cfg_data
);
	logic [SizeW-1:0] table_size_q, second_mod_q;
	logic probe_mode_q;
	logic job_valid, job_ready, clearing;
	job_t job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= SizeW'(1024);
			second_mod_q <= SizeW'(7);
			probe_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TABLE_SIZE: table_size_q <= cfg_data;
				CFG_SECOND_MOD: second_mod_q <= cfg_data;
				CFG_PROBE_MODE: probe_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ohs_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.table_size_q(table_size_q), .second_mod_q(second_mod_q),
		.probe_mode_q(probe_mode_q),
		.job_valid(job_valid), .job_ready(job_ready), .job(job)
	);

	ohs_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid),
		.job_ready(job_ready), .job(job), .rsp(rsp), .clearing(clearing)
	);

	a_no_job_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !job_ready)
		else $error("job taken during clear");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.load_count))
		else $error("result dropped");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.load_count <= CntW'(MaxSlots))
		else $error("count overflow");
endmodule
`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench of the open-addressing hash set with its own shadow table.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import ohs_pkg::*;

	localparam int CycleLimit = 10_000_000;

	typedef struct {
		bit              is_cfg;
		logic [1:0]      req_type;
		logic [KeyW-1:0] key;
		int              size;
		int              rmod;
		bit              mode;
		bit              typed;
		bit              success;
		int              load_count;
	} step_row_t;

	typedef struct {
		int size;
		int rmod;
		bit mode;
		int n_items;
		int pool_n;
		int hold;
		bit idle;
	} phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [SizeW-1:0] cfg_data;

	ohs_req_if req_ch();
	ohs_rsp_if rsp_ch();

	open_addressing_hash_set DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the table and its settings.
	logic [SizeW-1:0] shadow_size;
	logic [SizeW-1:0] shadow_rmod;
	bit               shadow_mode;
	logic [KeyW-1:0]  shadow_key [MaxSlots];
	logic [1:0]       shadow_status [MaxSlots];
	int               shadow_count;

	rsp_t pending_results [$];
	rsp_t typed_results [$];
	int   errors = 0;
	int   cycles = 0;
	bit   idle_on = 1'b1;
	int   hold_off = 0;
	int   recv_burst = 0;

	function automatic int slot_of(logic [KeyW-1:0] k, int i, int sz);
		logic [31:0] step;
		logic [31:0] r;
		logic [31:0] ii;
		ii = i;
		if (!shadow_mode) begin
			step = ii * ii;
		end else begin
			r = (shadow_rmod == 0) ? 32'd1 : 32'(shadow_rmod);
			step = ii * (r - k % r);
		end
		return int'((k + step) % 32'(sz));
	endfunction

	function automatic int find_slot(logic [KeyW-1:0] k, int sz);
		int p;
		for (int i = 0; i < sz; i++) begin
			p = slot_of(k, i, sz);
			if (shadow_status[p] == ST_EMPTY) return sz;
			if (shadow_status[p] == ST_OCCUPIED && shadow_key[p] == k) return p;
		end
		return sz;
	endfunction

	function automatic rsp_t hash_set_predict(logic [1:0] rt, logic [KeyW-1:0] k);
		rsp_t r;
		int sz;
		int p;
		sz = (shadow_size == 0) ? 1 : (shadow_size > MaxSlots ? MaxSlots : int'(shadow_size));
		r.success = 1'b0;
		case (rt)
			REQ_INSERT: begin
				for (int i = 0; i < sz; i++) begin
					p = slot_of(k, i, sz);
					if (shadow_status[p] != ST_OCCUPIED) begin
						shadow_key[p] = k;
						shadow_status[p] = ST_OCCUPIED;
						shadow_count++;
						r.success = 1'b1;
						break;
					end
				end
			end
			REQ_CONTAINS: r.success = find_slot(k, sz) < sz;
			REQ_REMOVE: begin
				p = find_slot(k, sz);
				if (p < sz) begin
					shadow_status[p] = ST_DELETED;
					shadow_count--;
					r.success = 1'b1;
				end
			end
			default: ;
		endcase
		r.load_count = CntW'(shadow_count);
		return r;
	endfunction

	// Result check first, then the prediction for a request taken at the same edge.
	always @(posedge clk) begin
		rsp_t exp_r;
		rsp_t pred;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no expectation: success=%0d load_count=%0d",
					rsp_ch.success, rsp_ch.load_count);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (rsp_ch.success !== exp_r.success) begin
					$error("success: expected %0d, got %0d", exp_r.success, rsp_ch.success);
					errors++;
				end
				if (rsp_ch.load_count !== exp_r.load_count) begin
					$error("load_count: expected %0d, got %0d", exp_r.load_count,
						rsp_ch.load_count);
					errors++;
				end
			end
		end
		if (req_ch.valid && req_ch.ready) begin
			pred = hash_set_predict(req_ch.req_type, req_ch.key);
			if (typed_results.size() != 0) pending_results.push_back(typed_results.pop_front());
			else pending_results.push_back(pred);
		end
	end

	// Receiver: random stall bursts plus one long hold-off.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off--;
			rsp_ch.ready <= 1'b0;
		end else if (recv_burst > 0) begin
			recv_burst--;
			rsp_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			recv_burst = $urandom_range(0, 13);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("open_addressing_hash_set regression: fail");
			$finish;
		end
	end

	task automatic write_cfg(int size, int rmod, bit mode);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TABLE_SIZE;
		cfg_data <= SizeW'(size);
		@(posedge clk);
		cfg_index <= CFG_SECOND_MOD;
		cfg_data <= SizeW'(rmod);
		@(posedge clk);
		cfg_index <= CFG_PROBE_MODE;
		cfg_data <= SizeW'(mode);
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_size = SizeW'(size);
		shadow_rmod = SizeW'(rmod);
		shadow_mode = mode;
	endtask

	// Leaves valid high so a following beat can go out back to back.
	task automatic send_beat(logic [1:0] rt, logic [KeyW-1:0] k);
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rt;
		req_ch.key <= k;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic sender_gap();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	step_row_t steps [] = '{
		'{0, REQ_CONTAINS, 32'h0000_0000, 0, 0, 0, 1, 0, 0},
		'{0, REQ_REMOVE,   32'h0000_0000, 0, 0, 0, 1, 0, 0},
		'{0, REQ_INSERT,   32'h0000_0000, 0, 0, 0, 1, 1, 1},
		'{0, REQ_INSERT,   32'h0000_0000, 0, 0, 0, 1, 1, 2},
		'{0, REQ_INSERT,   32'hFFFF_FFFF, 0, 0, 0, 1, 1, 3},
		'{0, REQ_CONTAINS, 32'hFFFF_FFFF, 0, 0, 0, 1, 1, 3},
		'{0, 2'd3,         32'hAAAA_5555, 0, 0, 0, 1, 0, 3},
		'{0, REQ_REMOVE,   32'h0000_0000, 0, 0, 0, 1, 1, 2},
		'{0, REQ_REMOVE,   32'h0000_0000, 0, 0, 0, 1, 1, 1},
		'{0, REQ_REMOVE,   32'h0000_0000, 0, 0, 0, 1, 0, 1},
		'{0, REQ_CONTAINS, 32'h0000_0000, 0, 0, 0, 1, 0, 1},
		'{0, REQ_INSERT,   32'h8000_0000, 0, 0, 0, 0, 0, 0},
		'{0, REQ_INSERT,   32'h5555_AAAA, 0, 0, 0, 0, 0, 0},
		'{0, REQ_CONTAINS, 32'h8000_0000, 0, 0, 0, 0, 0, 0},
		'{1, 2'd0,         32'h0,         1, 0, 1, 0, 0, 0},
		'{0, REQ_INSERT,   32'h0000_0007, 0, 0, 0, 0, 0, 0},
		'{0, REQ_INSERT,   32'h0000_0008, 0, 0, 0, 0, 0, 0},
		'{0, REQ_REMOVE,   32'h8000_0000, 0, 0, 0, 0, 0, 0},
		'{0, REQ_INSERT,   32'h0000_0008, 0, 0, 0, 0, 0, 0},
		'{1, 2'd0,         32'h0,         2047, 2047, 1, 0, 0, 0},
		'{0, REQ_INSERT,   32'hFFFF_FFFE, 0, 0, 0, 0, 0, 0},
		'{0, REQ_CONTAINS, 32'h5555_AAAA, 0, 0, 0, 0, 0, 0},
		'{0, REQ_REMOVE,   32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0}
	};

	phase_t phases [] = '{
		'{1024, 7,    0, 150, 64, 0,   1},
		'{1,    1,    0, 60,  4,  0,   1},
		'{2,    2047, 1, 60,  6,  0,   1},
		'{13,   5,    1, 200, 24, 0,   1},
		'{16,   0,    1, 150, 24, 0,   1},
		'{0,    3,    1, 40,  4,  0,   1},
		'{64,   1024, 0, 200, 80, 400, 1},
		'{2047, 1,    1, 150, 64, 0,   1},
		'{37,   31,   0, 200, 40, 0,   0}
	};

	initial begin
		rsp_t t;
		logic [KeyW-1:0] pool [$];
		int pick;
		logic [1:0] rt;
		logic [KeyW-1:0] k;

		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_INSERT;
		req_ch.key <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_TABLE_SIZE;
		cfg_data <= '0;
		shadow_size = 11'd1024;
		shadow_rmod = 11'd7;
		shadow_mode = 1'b0;
		shadow_count = 0;
		for (int i = 0; i < MaxSlots; i++) shadow_status[i] = ST_EMPTY;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].is_cfg) begin
				wait_drained();
				write_cfg(steps[i].size, steps[i].rmod, steps[i].mode);
			end else begin
				if (steps[i].typed) begin
					t.success = steps[i].success;
					t.load_count = CntW'(steps[i].load_count);
					typed_results.push_back(t);
				end
				send_beat(steps[i].req_type, steps[i].key);
				sender_gap();
			end
		end

		foreach (phases[ph]) begin
			wait_drained();
			idle_on = phases[ph].idle;
			write_cfg(phases[ph].size, phases[ph].rmod, phases[ph].mode);
			pool.delete();
			for (int i = 0; i < phases[ph].pool_n; i++) pool.push_back($urandom());
			// The hold-off makes the block back up while requests keep coming.
			hold_off = phases[ph].hold;
			for (int n = 0; n < phases[ph].n_items; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) rt = REQ_INSERT;
				else if (pick < 70) rt = REQ_CONTAINS;
				else if (pick < 95) rt = REQ_REMOVE;
				else rt = 2'd3;
				if ($urandom_range(0, 9) < 7) k = pool[$urandom_range(0, pool.size() - 1)];
				else k = $urandom();
				send_beat(rt, k);
				sender_gap();
			end
		end

		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("open_addressing_hash_set regression: pass");
		end else begin
			$display("open_addressing_hash_set regression: fail");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
design/ohs_pkg.sv
design/ohs_if.sv
design/ohs_ram.sv
design/ohs_front.sv
design/ohs_back.sv
design/open_addressing_hash_set.sv
test/tb.sv
